// ===== rtl/mpid_pkg.sv =====
package mpid_pkg;

    localparam int CH_W       = 3;
    localparam int CH_CMP_W   = 7;
    localparam int POS_W      = 12;
    localparam int KP_W       = 8;
    localparam int KD_W       = 8;
    localparam int KI_W       = 20;
    localparam int LIM_W      = 12;
    localparam int ERR_W      = 13;
    localparam int INTEG_W    = 30;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int CHANNELS_DEF = 6;

    localparam logic [KP_W-1:0]  KP_RST   = 8'd24;
    localparam logic [KD_W-1:0]  KD_RST   = 8'd15;
    localparam logic [KI_W-1:0]  KI_RST   = 20'd13107;
    localparam logic [LIM_W-1:0] ILIM_RST = 12'd4095;
    localparam logic [LIM_W-1:0] OLIM_RST = 12'd3500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP   = 3'd0,
        CFG_KD   = 3'd1,
        CFG_KI   = 3'd2,
        CFG_ILIM = 3'd3,
        CFG_OLIM = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ERR_W-1:0]   last_err;
        logic signed [INTEG_W-1:0] integ;
    } t_chan_state;

    typedef struct packed {
        logic [KP_W-1:0]  kp;
        logic [KD_W-1:0]  kd;
        logic [KI_W-1:0]  ki_step;
        logic [LIM_W-1:0] integral_limit;
        logic [LIM_W-1:0] output_limit;
    } t_gains;

endpackage

// ===== rtl/mpid_in_if.sv =====
interface mpid_in_if;
    logic                       valid;
    logic                       ready;
    logic [mpid_pkg::CH_W-1:0]  channel;
    logic [mpid_pkg::POS_W-1:0] setpoint;
    logic [mpid_pkg::POS_W-1:0] measured;
    logic                       drive_enable;

    modport source (output valid, channel, setpoint, measured, drive_enable, input ready);
    modport sink   (input valid, channel, setpoint, measured, drive_enable, output ready);
endinterface

// ===== rtl/mpid_out_if.sv =====
interface mpid_out_if;
    logic                       valid;
    logic                       ready;
    logic [mpid_pkg::CH_W-1:0]  out_channel;
    logic [mpid_pkg::POS_W-1:0] duty;
    logic                       dir_forward;
    logic                       dir_reverse;

    modport source (output valid, out_channel, duty, dir_forward, dir_reverse, input ready);
    modport sink   (input valid, out_channel, duty, dir_forward, dir_reverse, output ready);
endinterface

// ===== rtl/multichannel_pid_motor_drive.sv =====
// Multichannel PID position controller for H-bridge motor drives.
// Input channel i_in: one word per control sample (channel, setpoint,
// measured, drive_enable). Output channel o_out: one word per input word
// (out_channel, duty, dir_forward, dir_reverse), in order.
// Both channels are valid/ready; a word moves when both are high.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high (0 kp, 1 kd, 2 ki_step, 3 integral_limit, 4 output_limit); write only
// while no word is in flight.
// An accepted word is registered in the input stage, then in the output
// register. Throughput: one word per cycle unless the receiver stalls, also
// back to back on one channel (per-channel state has a write-through bypass).
// The PID math sits between the input stage register and the output register.
// Reset (synchronous, active low) restores the default gains and clears every
// channel's error and integral state through per-channel valid bits.
// When the receiver stalls, the output word holds; one more word sits in the
// input stage, then i_in.ready drops until the output drains.
// Words for channels at or above CHANNELS pass through with zero drive and
// leave the state untouched.
module multichannel_pid_motor_drive #(
    parameter int CHANNELS = mpid_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mpid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mpid_in_if.sink                         i_in,
    mpid_out_if.source                      o_out
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mpid_pkg::t_gains r_gains;

    logic                        r_s1_v;
    logic [mpid_pkg::CH_W-1:0]   r_s1_ch;
    logic [mpid_pkg::POS_W-1:0]  r_s1_sp;
    logic [mpid_pkg::POS_W-1:0]  r_s1_ms;
    logic                        r_s1_en;
    logic                        r_s1_inr;

    logic                        r_out_v;
    logic                        n_out_v;
    logic [mpid_pkg::CH_W-1:0]   r_out_ch;
    logic [mpid_pkg::POS_W-1:0]  r_out_duty;
    logic                        r_out_fwd;
    logic                        r_out_rev;

    logic [mpid_pkg::CH_CMP_W-1:0] in_ch_w;
    logic [mpid_pkg::CH_CMP_W-1:0] s1_ch_w;
    logic                          in_range;
    logic                          accept;
    logic                          s1_adv;
    logic                          wr_en;

    mpid_pkg::t_chan_state rd_state;
    mpid_pkg::t_chan_state wr_state;
    logic [mpid_pkg::POS_W-1:0] calc_duty;
    logic                       calc_fwd;
    logic                       calc_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp             <= mpid_pkg::KP_RST;
            r_gains.kd             <= mpid_pkg::KD_RST;
            r_gains.ki_step        <= mpid_pkg::KI_RST;
            r_gains.integral_limit <= mpid_pkg::ILIM_RST;
            r_gains.output_limit   <= mpid_pkg::OLIM_RST;
        end else if (i_cfg_we) begin
            case (mpid_pkg::t_cfg_idx'(i_cfg_idx))
                mpid_pkg::CFG_KP:   r_gains.kp             <= i_cfg_data[mpid_pkg::KP_W-1:0];
                mpid_pkg::CFG_KD:   r_gains.kd             <= i_cfg_data[mpid_pkg::KD_W-1:0];
                mpid_pkg::CFG_KI:   r_gains.ki_step        <= i_cfg_data[mpid_pkg::KI_W-1:0];
                mpid_pkg::CFG_ILIM: r_gains.integral_limit <= i_cfg_data[mpid_pkg::LIM_W-1:0];
                mpid_pkg::CFG_OLIM: r_gains.output_limit   <= i_cfg_data[mpid_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_ch_w  = {{(mpid_pkg::CH_CMP_W-mpid_pkg::CH_W){1'b0}}, i_in.channel};
    assign s1_ch_w  = {{(mpid_pkg::CH_CMP_W-mpid_pkg::CH_W){1'b0}}, r_s1_ch};
    assign in_range = in_ch_w < mpid_pkg::CH_CMP_W'(CHANNELS);
    assign s1_adv   = r_s1_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s1_adv;
    assign accept   = i_in.valid && i_in.ready;
    assign wr_en    = s1_adv && r_s1_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch  <= i_in.channel;
            r_s1_sp  <= i_in.setpoint;
            r_s1_ms  <= i_in.measured;
            r_s1_en  <= i_in.drive_enable;
            r_s1_inr <= in_range;
        end
    end

    mpid_state #(.CHANNELS(CHANNELS)) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && in_range),
        .i_rd_idx  (in_ch_w[IDX_W-1:0]),
        .i_wr_en   (wr_en),
        .i_wr_idx  (s1_ch_w[IDX_W-1:0]),
        .i_wr_data (wr_state),
        .o_rd_data (rd_state)
    );

    mpid_calc u_calc (
        .i_gains        (r_gains),
        .i_in_range     (r_s1_inr),
        .i_drive_enable (r_s1_en),
        .i_setpoint     (r_s1_sp),
        .i_measured     (r_s1_ms),
        .i_state        (rd_state),
        .o_state        (wr_state),
        .o_duty         (calc_duty),
        .o_dir_forward  (calc_fwd),
        .o_dir_reverse  (calc_rev)
    );

    always_comb begin
        if (s1_adv) begin
            n_out_v = 1'b1;
        end else if (o_out.ready) begin
            n_out_v = 1'b0;
        end else begin
            n_out_v = r_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_ch   <= r_s1_ch;
            r_out_duty <= calc_duty;
            r_out_fwd  <= calc_fwd;
            r_out_rev  <= calc_rev;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.out_channel = r_out_ch;
    assign o_out.duty        = r_out_duty;
    assign o_out.dir_forward = r_out_fwd;
    assign o_out.dir_reverse = r_out_rev;

`ifndef SYNTHESIS
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (s1_ch_w < mpid_pkg::CH_CMP_W'(CHANNELS)))
        else $error("state write to out-of-range channel");

    a_dir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out_fwd && r_out_rev))
        else $error("both direction bits set");

    a_idle_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_fwd && !r_out_rev) |-> (r_out_duty == '0))
        else $error("nonzero duty with no direction");

    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_duty <= r_gains.output_limit))
        else $error("duty above output limit");

    a_adv_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_v)
        else $error("stage advance lost a word");
`endif
endmodule

// ===== rtl/mpid_state.sv =====
module mpid_state #(
    parameter  int CHANNELS = mpid_pkg::CHANNELS_DEF,
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  mpid_pkg::t_chan_state i_wr_data,
    output mpid_pkg::t_chan_state o_rd_data
);
    mpid_pkg::t_chan_state r_mem [CHANNELS];
    mpid_pkg::t_chan_state r_rd_data;
    logic [CHANNELS-1:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_idx] <= 1'b1;
        end
    end

    // write-through bypass for back-to-back words on one channel
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_data <= i_wr_data;
            end else if (r_vld[i_rd_idx]) begin
                r_rd_data <= r_mem[i_rd_idx];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/mpid_calc.sv =====
module mpid_calc (
    input  mpid_pkg::t_gains              i_gains,
    input  logic                          i_in_range,
    input  logic                          i_drive_enable,
    input  logic [mpid_pkg::POS_W-1:0]    i_setpoint,
    input  logic [mpid_pkg::POS_W-1:0]    i_measured,
    input  mpid_pkg::t_chan_state         i_state,
    output mpid_pkg::t_chan_state         o_state,
    output logic [mpid_pkg::POS_W-1:0]    o_duty,
    output logic                          o_dir_forward,
    output logic                          o_dir_reverse
);
    logic signed [12:0] err;
    logic signed [13:0] derr;
    logic signed [33:0] ki_prod;
    logic signed [34:0] isum;
    logic signed [34:0] ilim_q;
    logic signed [29:0] integ_n;
    logic signed [21:0] p_term;
    logic signed [22:0] d_term;
    logic signed [23:0] pd_sum;
    logic signed [39:0] sum_q;
    logic signed [23:0] drv;
    logic signed [23:0] olim;
    logic signed [12:0] drv_c;
    logic signed [12:0] mag;

    always_comb begin
        err     = $signed({1'b0, i_setpoint}) - $signed({1'b0, i_measured});
        derr    = $signed({err[12], err}) - $signed({i_state.last_err[12], i_state.last_err});
        ki_prod = $signed({1'b0, i_gains.ki_step}) * err;
        isum    = $signed({{5{i_state.integ[29]}}, i_state.integ})
                + $signed({ki_prod[33], ki_prod});
        ilim_q  = $signed({7'd0, i_gains.integral_limit, 16'd0});
        if (isum > ilim_q) begin
            integ_n = ilim_q[29:0];
        end else if (isum < -ilim_q) begin
            integ_n = 30'(-ilim_q);
        end else begin
            integ_n = isum[29:0];
        end

        p_term = $signed({1'b0, i_gains.kp}) * err;
        d_term = $signed({1'b0, i_gains.kd}) * derr;
        pd_sum = $signed({{2{p_term[21]}}, p_term}) + $signed({d_term[22], d_term});
        sum_q  = $signed({pd_sum, 16'd0}) + $signed({{10{integ_n[29]}}, integ_n});

        // truncate toward zero
        drv = sum_q[39:16] + 24'(sum_q[39] && (|sum_q[15:0]));

        olim = $signed({12'd0, i_gains.output_limit});
        if (drv > olim) begin
            drv_c = olim[12:0];
        end else if (drv < -olim) begin
            drv_c = 13'(-olim);
        end else begin
            drv_c = drv[12:0];
        end
        mag = drv_c[12] ? -drv_c : drv_c;

        o_dir_forward = i_in_range && i_drive_enable && !drv_c[12] && (drv_c != '0);
        o_dir_reverse = i_in_range && i_drive_enable && drv_c[12];
        o_duty        = (o_dir_forward || o_dir_reverse) ? mag[11:0] : '0;

        o_state.last_err = err;
        o_state.integ    = integ_n;
    end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int NCH = mpid_pkg::CHANNELS_DEF;
    localparam longint Q_ONE = longint'(1) << mpid_pkg::FRAC_W;

    typedef struct packed {
        logic [mpid_pkg::CH_W-1:0]  ch;
        logic [mpid_pkg::POS_W-1:0] sp;
        logic [mpid_pkg::POS_W-1:0] ms;
        logic                       en;
    } t_sample;

    typedef struct packed {
        logic [mpid_pkg::CH_W-1:0]  ch;
        logic [mpid_pkg::POS_W-1:0] duty;
        logic                       fwd;
        logic                       rev;
    } t_drive;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [mpid_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [mpid_pkg::CFG_DATA_W-1:0] cfg_data;

    mpid_in_if  in_ch();
    mpid_out_if out_ch();

    multichannel_pid_motor_drive #(.CHANNELS(NCH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    mpid_pkg::t_gains                  gains;
    logic signed [mpid_pkg::ERR_W-1:0] last_err [NCH];
    longint                            integ_q  [NCH];

    t_sample sample_q[$];
    t_drive  drive_expected[$];

    int mismatches = 0;
    bit calm       = 1'b0;
    int in_gap     = 0;
    int out_stall  = 0;
    bit in_taken   = 1'b0;
    bit out_taken  = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_drive predict_drive(t_sample s);
        longint e, de, acc, sum, drv;
        t_drive r;
        r    = '0;
        r.ch = s.ch;
        if (s.ch >= NCH) return r;
        e  = longint'(s.sp) - longint'(s.ms);
        de = e - longint'(last_err[s.ch]);
        last_err[s.ch] = e[mpid_pkg::ERR_W-1:0];
        acc = integ_q[s.ch] + longint'(gains.ki_step) * e;
        acc = clamp_mag(acc, longint'(gains.integral_limit) * Q_ONE);
        integ_q[s.ch] = acc;
        sum = (longint'(gains.kp) * e + longint'(gains.kd) * de) * Q_ONE + acc;
        drv = clamp_mag(sum / Q_ONE, longint'(gains.output_limit));
        if (s.en && drv > 0) begin
            r.duty = drv[mpid_pkg::POS_W-1:0];
            r.fwd  = 1'b1;
        end else if (s.en && drv < 0) begin
            drv    = -drv;
            r.duty = drv[mpid_pkg::POS_W-1:0];
            r.rev  = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(string why, t_drive want, t_drive got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("mismatch (%s): exp ch=%0d duty=%0d fwd=%0b rev=%0b, ",
                   why, want.ch, want.duty, want.fwd, want.rev);
            $display("got ch=%0d duty=%0d fwd=%0b rev=%0b",
                     got.ch, got.duty, got.fwd, got.rev);
        end
    endtask

    always @(posedge i_clk) begin : check
        t_drive got;
        t_drive want;
        in_taken  <= in_ch.valid && in_ch.ready;
        out_taken <= out_ch.valid && out_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.out_channel, out_ch.duty, out_ch.dir_forward, out_ch.dir_reverse};
                if (drive_expected.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = drive_expected.pop_front();
                    if (got !== want) note_mismatch("field", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready)
                drive_expected.push_back(predict_drive({in_ch.channel, in_ch.setpoint,
                                                        in_ch.measured, in_ch.drive_enable}));
        end
    end

    always @(negedge i_clk) begin : feed
        t_sample s;
        if (!in_ch.valid || in_taken) begin
            if (in_gap > 0 || sample_q.size() == 0) begin
                if (in_gap > 0) in_gap--;
                in_ch.valid <= 1'b0;
            end else begin
                s = sample_q.pop_front();
                in_ch.channel      <= s.ch;
                in_ch.setpoint     <= s.sp;
                in_ch.measured     <= s.ms;
                in_ch.drive_enable <= s.en;
                in_ch.valid        <= 1'b1;
                in_gap = calm ? 0 : $urandom_range(0, 14);
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_taken) out_stall = calm ? 0 : $urandom_range(0, 14);
        if (out_stall > 0) begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(mpid_pkg::t_cfg_idx idx, logic [mpid_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            mpid_pkg::CFG_KP:   gains.kp             = val[mpid_pkg::KP_W-1:0];
            mpid_pkg::CFG_KD:   gains.kd             = val[mpid_pkg::KD_W-1:0];
            mpid_pkg::CFG_KI:   gains.ki_step        = val[mpid_pkg::KI_W-1:0];
            mpid_pkg::CFG_ILIM: gains.integral_limit = val[mpid_pkg::LIM_W-1:0];
            mpid_pkg::CFG_OLIM: gains.output_limit   = val[mpid_pkg::LIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(int kp, int kd, int ki, int ilim, int olim);
        write_reg(mpid_pkg::CFG_KP, mpid_pkg::CFG_DATA_W'(kp));
        write_reg(mpid_pkg::CFG_KD, mpid_pkg::CFG_DATA_W'(kd));
        write_reg(mpid_pkg::CFG_KI, mpid_pkg::CFG_DATA_W'(ki));
        write_reg(mpid_pkg::CFG_ILIM, mpid_pkg::CFG_DATA_W'(ilim));
        write_reg(mpid_pkg::CFG_OLIM, mpid_pkg::CFG_DATA_W'(olim));
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (!(sample_q.size() == 0 && !in_ch.valid && drive_expected.size() == 0));
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        int      r;
        int      m;
        r    = $urandom_range(0, 99);
        s.ch = ($urandom_range(0, 19) == 0) ? mpid_pkg::CH_W'($urandom_range(NCH, 7))
                                            : mpid_pkg::CH_W'($urandom_range(0, NCH - 1));
        s.en = ($urandom_range(0, 6) != 0);
        s.sp = mpid_pkg::POS_W'($urandom_range(0, 4095));
        if (r < 50) begin
            m = int'(s.sp) + int'($urandom_range(0, 128)) - 64;
            if (m < 0) m = 0;
            if (m > 4095) m = 4095;
            s.ms = mpid_pkg::POS_W'(m);
        end else if (r < 80) begin
            s.ms = mpid_pkg::POS_W'($urandom);
        end else begin
            s.sp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            s.ms = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        end
        return s;
    endfunction

    task automatic run_random(int n, bit no_idle, bit hold_mid);
        calm = no_idle;
        repeat (n / 2) sample_q.push_back(rand_sample());
        if (hold_mid) wait_idle();
        repeat (n - n / 2) sample_q.push_back(rand_sample());
        wait_idle();
    endtask

    task automatic push_sample(int ch, int sp, int ms, bit en);
        t_sample s;
        s.ch = mpid_pkg::CH_W'(ch);
        s.sp = mpid_pkg::POS_W'(sp);
        s.ms = mpid_pkg::POS_W'(ms);
        s.en = en;
        sample_q.push_back(s);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.channel      = '0;
        in_ch.setpoint     = '0;
        in_ch.measured     = '0;
        in_ch.drive_enable = 1'b0;
        out_ch.ready       = 1'b0;
        gains.kp             = mpid_pkg::KP_RST;
        gains.kd             = mpid_pkg::KD_RST;
        gains.ki_step        = mpid_pkg::KI_RST;
        gains.integral_limit = mpid_pkg::ILIM_RST;
        gains.output_limit   = mpid_pkg::OLIM_RST;
        for (int i = 0; i < NCH; i++) begin
            last_err[i] = '0;
            integ_q[i]  = 0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);

        // reset gains: saturation both ways, zero drive, disable, bad channels
        push_sample(0, 4095, 0, 1'b1);
        push_sample(0, 0, 4095, 1'b1);
        push_sample(0, 2048, 2048, 1'b1);
        push_sample(0, 2048, 2048, 1'b1);
        push_sample(1, 4095, 0, 1'b0);
        push_sample(1, 4095, 0, 1'b1);
        push_sample(6, 4095, 0, 1'b1);
        push_sample(7, 0, 4095, 1'b1);
        push_sample(5, 4095, 0, 1'b1);
        push_sample(5, 4095, 0, 1'b1);
        push_sample(5, 0, 4095, 1'b1);
        push_sample(2, 1000, 999, 1'b1);
        push_sample(2, 999, 1000, 1'b1);
        push_sample(2, 1000, 1000, 1'b1);
        push_sample(3, 0, 0, 1'b0);
        push_sample(4, 4095, 4095, 1'b1);
        push_sample(3, 3000, 100, 1'b0);
        push_sample(3, 3000, 100, 1'b1);
        push_sample(4, 100, 3000, 1'b1);
        push_sample(6, 0, 0, 1'b0);
        wait_idle();

        set_gains(1, 0, 655, 100, 4095);
        run_random(118, 1'b0, 1'b1);

        set_gains(255, 255, 1048575, 4095, 4095);
        run_random(118, 1'b1, 1'b0);

        set_gains(0, 0, 0, 0, 0);
        run_random(60, 1'b0, 1'b0);

        set_gains(0, 0, $urandom_range(0, 1048575), 0, $urandom_range(0, 4095));
        run_random(60, 1'b0, 1'b0);

        set_gains(0, 0, $urandom_range(1000, 200000), $urandom_range(0, 4095), 4095);
        run_random(118, 1'b0, 1'b1);

        for (int p = 0; p < 3; p++) begin
            set_gains($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255),
                      $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255),
                      $urandom_range(0, 1) ? $urandom_range(0, 70000)
                                           : $urandom_range(0, 1048575),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
            run_random(118, p == 1, 1'b0);
        end

        set_gains(int'(mpid_pkg::KP_RST), int'(mpid_pkg::KD_RST), int'(mpid_pkg::KI_RST),
                  int'(mpid_pkg::ILIM_RST), int'(mpid_pkg::OLIM_RST));
        run_random(118, 1'b0, 1'b0);

        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
